### sv/rmq_pkg.sv
// Shared types, widths and helpers for the rotation matrix to quaternion block.
package rmq_pkg;

  localparam int ROOT_W   = 23;
  localparam int RAD_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int Q_W      = 17;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = Q_W + 2;
  localparam int TOT_LAT  = SQRT_LAT + DIV_LAT + 2;

  localparam logic [1:0] AX_TR = 2'd0;
  localparam logic [1:0] AX_X  = 2'd1;
  localparam logic [1:0] AX_Y  = 2'd2;
  localparam logic [1:0] AX_Z  = 2'd3;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               bad_input;
  } out_t;

  typedef struct packed {
    logic [1:0]                axis;
    logic                      bad;
    logic [RAD_W-1:0]          rad;
    logic signed [DIFF_W-1:0]  d0;
    logic signed [DIFF_W-1:0]  d1;
    logic signed [DIFF_W-1:0]  d2;
  } fe_t;

  typedef struct packed {
    logic [1:0]  axis;
    logic        bad;
    logic [14:0] big;
  } side_t;

  typedef struct packed {
    logic           neg;
    logic           ovf;
    logic [Q_W-1:0] q;
  } div_res_t;

  function automatic logic signed [15:0] sat_comp(input div_res_t r);
    logic signed [15:0] res;
    if (r.neg) begin
      if (r.ovf || r.q > Q_W'(32768)) begin
        res = -16'sd32768;
      end else begin
        res = 16'(-$signed({1'b0, r.q}));
      end
    end else begin
      if (r.ovf || r.q > Q_W'(32767)) begin
        res = 16'sd32767;
      end else begin
        res = 16'(r.q);
      end
    end
    return res;
  endfunction

endpackage

### sv/rmq_front.sv
// Front stage: trace, branch choice, radicand and component differences.
module rmq_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         acc,
  input  rmq_pkg::in_t in_data,
  output logic         fe_valid,
  output rmq_pkg::fe_t fe_data
);

  logic         valid_r;
  rmq_pkg::fe_t data_r;
  rmq_pkg::fe_t data_nxt;

  logic signed [18:0] e00, e11, e22, tr, rad;

  always_comb begin
    e00 = 19'(in_data.r00);
    e11 = 19'(in_data.r11);
    e22 = 19'(in_data.r22);
    tr  = e00 + e11 + e22;
    if (tr > 19'sd0) begin
      data_nxt.axis = rmq_pkg::AX_TR;
      rad = 19'sd16384 + tr;
      data_nxt.d0 = 18'(in_data.r21) - 18'(in_data.r12);
      data_nxt.d1 = 18'(in_data.r02) - 18'(in_data.r20);
      data_nxt.d2 = 18'(in_data.r10) - 18'(in_data.r01);
    end else if (in_data.r00 > in_data.r11 && in_data.r00 > in_data.r22) begin
      data_nxt.axis = rmq_pkg::AX_X;
      rad = 19'sd16384 + e00 - e11 - e22;
      data_nxt.d0 = 18'(in_data.r21) - 18'(in_data.r12);
      data_nxt.d1 = 18'(in_data.r01) + 18'(in_data.r10);
      data_nxt.d2 = 18'(in_data.r02) + 18'(in_data.r20);
    end else if (in_data.r11 > in_data.r22) begin
      data_nxt.axis = rmq_pkg::AX_Y;
      rad = 19'sd16384 + e11 - e00 - e22;
      data_nxt.d0 = 18'(in_data.r02) - 18'(in_data.r20);
      data_nxt.d1 = 18'(in_data.r01) + 18'(in_data.r10);
      data_nxt.d2 = 18'(in_data.r12) + 18'(in_data.r21);
    end else begin
      data_nxt.axis = rmq_pkg::AX_Z;
      rad = 19'sd16384 + e22 - e00 - e11;
      data_nxt.d0 = 18'(in_data.r10) - 18'(in_data.r01);
      data_nxt.d1 = 18'(in_data.r02) + 18'(in_data.r20);
      data_nxt.d2 = 18'(in_data.r12) + 18'(in_data.r21);
    end
    data_nxt.bad = (rad <= 19'sd0);
    data_nxt.rad = data_nxt.bad ? rmq_pkg::RAD_W'(1) : rad[rmq_pkg::RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign fe_valid = valid_r;
  assign fe_data  = data_r;

endmodule

### sv/rmq_sqrt.sv
// Pipelined integer square root of rad * 2^28, one result bit per stage.
module rmq_sqrt (
  input  logic                         clk,
  input  logic [rmq_pkg::RAD_W-1:0]    rad,
  output logic [rmq_pkg::ROOT_W-1:0]   root
);

  localparam int RW = rmq_pkg::ROOT_W;
  localparam int RM = RW + 4;
  localparam int NW = 2 * RW;

  logic [RM-1:0]                 rem_r [0:RW-1];
  logic [RW-1:0]                 p_r   [0:RW-1];
  logic [rmq_pkg::RAD_W-1:0]     a_r   [0:RW-1];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int I = RW - 1 - s;
    logic [RM-1:0]             rem_in, rem_s, trial;
    logic [RW-1:0]             p_in;
    logic [rmq_pkg::RAD_W-1:0] a_in;
    logic [NW-1:0]             n_w;
    logic [RM-1:0]             rem_nxt;
    logic [RW-1:0]             p_nxt;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign p_in   = '0;
      assign a_in   = rad;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign p_in   = p_r[s-1];
      assign a_in   = a_r[s-1];
    end

    always_comb begin
      n_w   = {{(NW - rmq_pkg::RAD_W - 28){1'b0}}, a_in, 28'd0};
      rem_s = {rem_in[RM-3:0], n_w[2*I+1 -: 2]};
      trial = {2'b00, p_in, 2'b01};
      if (rem_s >= trial) begin
        rem_nxt = rem_s - trial;
        p_nxt   = {p_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_s;
        p_nxt   = {p_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      p_r[s]   <= p_nxt;
      a_r[s]   <= a_in;
    end
  end

  assign root = p_r[RW-1];

endmodule

### sv/rmq_div.sv
// Pipelined rounded divider lane: |d| * 2^20 / root, one quotient bit per stage.
module rmq_div (
  input  logic                               clk,
  input  logic signed [rmq_pkg::DIFF_W-1:0]  d,
  input  logic [rmq_pkg::ROOT_W-1:0]         root,
  output rmq_pkg::div_res_t                  res
);

  localparam int QW = rmq_pkg::Q_W;
  localparam int NL = rmq_pkg::DIV_LAT;
  localparam int RW = 41;

  logic [RW-1:0]                   rem_r  [0:NL-1];
  logic [QW-1:0]                   q_r    [0:NL-1];
  logic                            ovf_r  [0:NL-1];
  logic                            neg_r  [0:NL-1];
  logic [rmq_pkg::ROOT_W-1:0]      root_r [0:NL-1];

  logic [16:0]                     mag;

  always_comb begin
    mag = d[rmq_pkg::DIFF_W-1] ? 17'(-d) : 17'(d);
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= RW'({mag, 20'd0}) + RW'(root[rmq_pkg::ROOT_W-1:1]);
    q_r[0]    <= '0;
    ovf_r[0]  <= 1'b0;
    neg_r[0]  <= d[rmq_pkg::DIFF_W-1];
    root_r[0] <= root;
  end

  always_ff @(posedge clk) begin
    rem_r[1]  <= rem_r[0];
    q_r[1]    <= q_r[0];
    ovf_r[1]  <= (rem_r[0] >= (RW'(root_r[0]) << QW));
    neg_r[1]  <= neg_r[0];
    root_r[1] <= root_r[0];
  end

  for (genvar k = 2; k < NL; k++) begin : g_bit
    localparam int B = NL - 1 - k;
    logic [RW-1:0] dv;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    always_comb begin
      dv = RW'(root_r[k-1]) << B;
      if (rem_r[k-1] >= dv) begin
        rem_nxt  = rem_r[k-1] - dv;
        q_nxt    = q_r[k-1];
        q_nxt[B] = 1'b1;
      end else begin
        rem_nxt = rem_r[k-1];
        q_nxt   = q_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      q_r[k]    <= q_nxt;
      ovf_r[k]  <= ovf_r[k-1];
      neg_r[k]  <= neg_r[k-1];
      root_r[k] <= root_r[k-1];
    end
  end

  assign res.neg = neg_r[NL-1];
  assign res.ovf = ovf_r[NL-1];
  assign res.q   = q_r[NL-1];

endmodule

### sv/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion converter, fully pipelined.
//
// A request is one 3x3 matrix of Q2.14 elements on in_data, taken at a
// rising edge where start is high and busy is low. Busy is low at all
// times outside reset, so a new request may be issued every cycle.
// The quaternion appears on out_data with out_valid high for exactly one
// cycle, after the request has passed one front stage for the
// branch choice, 23 square root stages (one root bit each), 19 divider
// stages (a set-up stage, an overflow test and one per quotient bit) and
// one output stage.
// Throughput is one request per cycle in steady state.
// The receiver cannot hold results off, and none is needed: results leave
// in request order at the rate they enter.
// The synchronous reset clears every valid bit in the pipeline, so
// requests in flight are dropped; busy is high while reset is asserted.
// A radicand that is not positive gives a zero quaternion with
// bad_input set.
module rotation_matrix_to_quaternion (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  output rmq_pkg::out_t out_data
);

  localparam int SL = rmq_pkg::SQRT_LAT;
  localparam int DL = rmq_pkg::DIV_LAT;

  logic          fe_valid;
  rmq_pkg::fe_t  fe_data;

  logic [rmq_pkg::ROOT_W-1:0] root;

  rmq_pkg::fe_t  s1_r [0:SL-1];
  logic [SL-1:0] v1_r;
  rmq_pkg::side_t s2_r [0:DL-1];
  logic [DL-1:0]  v2_r;
  rmq_pkg::side_t s2_nxt;

  rmq_pkg::div_res_t r0, r1, r2;
  logic signed [15:0] c0, c1, c2, bg;

  logic          out_valid_r;
  rmq_pkg::out_t out_r;
  rmq_pkg::out_t out_nxt;

  assign busy = ~rst_n;

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (start & ~busy),
    .in_data  (in_data),
    .fe_valid (fe_valid),
    .fe_data  (fe_data)
  );

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .rad  (fe_data.rad),
    .root (root)
  );

  always_ff @(posedge clk) begin
    s1_r[0] <= fe_data;
    for (int k = 1; k < SL; k++) begin
      s1_r[k] <= s1_r[k-1];
    end
  end

  always_comb begin
    s2_nxt.axis = s1_r[SL-1].axis;
    s2_nxt.bad  = s1_r[SL-1].bad;
    s2_nxt.big  = root[rmq_pkg::ROOT_W-1:8];
  end

  always_ff @(posedge clk) begin
    s2_r[0] <= s2_nxt;
    for (int k = 1; k < DL; k++) begin
      s2_r[k] <= s2_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= '0;
      v2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= {v1_r[SL-2:0], fe_valid};
      v2_r        <= {v2_r[DL-2:0], v1_r[SL-1]};
      out_valid_r <= v2_r[DL-1];
    end
  end

  rmq_div u_div0 (.clk(clk), .d(s1_r[SL-1].d0), .root(root), .res(r0));
  rmq_div u_div1 (.clk(clk), .d(s1_r[SL-1].d1), .root(root), .res(r1));
  rmq_div u_div2 (.clk(clk), .d(s1_r[SL-1].d2), .root(root), .res(r2));

  always_comb begin
    c0 = rmq_pkg::sat_comp(r0);
    c1 = rmq_pkg::sat_comp(r1);
    c2 = rmq_pkg::sat_comp(r2);
    bg = 16'($unsigned(s2_r[DL-1].big));
    case (s2_r[DL-1].axis)
      rmq_pkg::AX_TR: begin
        out_nxt.quat_w = bg; out_nxt.quat_x = c0;
        out_nxt.quat_y = c1; out_nxt.quat_z = c2;
      end
      rmq_pkg::AX_X: begin
        out_nxt.quat_w = c0; out_nxt.quat_x = bg;
        out_nxt.quat_y = c1; out_nxt.quat_z = c2;
      end
      rmq_pkg::AX_Y: begin
        out_nxt.quat_w = c0; out_nxt.quat_x = c1;
        out_nxt.quat_y = bg; out_nxt.quat_z = c2;
      end
      default: begin
        out_nxt.quat_w = c0; out_nxt.quat_x = c1;
        out_nxt.quat_y = c2; out_nxt.quat_z = bg;
      end
    endcase
    out_nxt.bad_input = s2_r[DL-1].bad;
    if (s2_r[DL-1].bad) begin
      out_nxt.quat_w = '0;
      out_nxt.quat_x = '0;
      out_nxt.quat_y = '0;
      out_nxt.quat_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/rmq_checker.sv
// Port-level checker for the rotation matrix to quaternion block, with its bind.
module rmq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input rmq_pkg::out_t out_data
);

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_input |->
      out_data.quat_w == 16'sd0 && out_data.quat_x == 16'sd0 &&
      out_data.quat_y == 16'sd0 && out_data.quat_z == 16'sd0)
    else $error("bad input result carries a non-zero quaternion");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised outside reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, rmq_pkg::TOT_LAT))
    else $error("result without a matching request");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### bench/rmq_checker.sv
// Checker for the rotation matrix to quaternion block: predicts each quaternion and compares.
`timescale 1ns / 1ps
module rmq_tb_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  rmq_pkg::in_t  in_data,
  input  logic          out_valid,
  input  rmq_pkg::out_t out_data,
  output int            errors,
  output int            pending
);

  rmq_pkg::out_t quat_queue[$];

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] scaled_ratio(input int d, input longint unsigned root);
    longint unsigned mag;
    longint unsigned q;
    mag = longint'(d < 0 ? -d : d) << 20;
    q = (mag + root / 2) / root;
    if (q > 65536) q = 65536;
    return clamp16(d < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic rmq_pkg::out_t quat_from_matrix(input rmq_pkg::in_t m);
    rmq_pkg::out_t o;
    int tr;
    int rad;
    logic [1:0] ax;
    longint unsigned root;
    logic signed [15:0] big;
    o = '0;
    tr = int'(m.r00) + int'(m.r11) + int'(m.r22);
    if (tr > 0) begin
      ax = rmq_pkg::AX_TR;
      rad = 16384 + tr;
    end else if (m.r00 > m.r11 && m.r00 > m.r22) begin
      ax = rmq_pkg::AX_X;
      rad = 16384 + m.r00 - m.r11 - m.r22;
    end else if (m.r11 > m.r22) begin
      ax = rmq_pkg::AX_Y;
      rad = 16384 + m.r11 - m.r00 - m.r22;
    end else begin
      ax = rmq_pkg::AX_Z;
      rad = 16384 + m.r22 - m.r00 - m.r11;
    end
    if (rad <= 0) begin
      o.bad_input = 1'b1;
      return o;
    end
    root = int_sqrt(longint'(rad) << 28);
    big = clamp16(longint'(root >> 8));
    case (ax)
      rmq_pkg::AX_TR: begin
        o.quat_w = big;
        o.quat_x = scaled_ratio(m.r21 - m.r12, root);
        o.quat_y = scaled_ratio(m.r02 - m.r20, root);
        o.quat_z = scaled_ratio(m.r10 - m.r01, root);
      end
      rmq_pkg::AX_X: begin
        o.quat_w = scaled_ratio(m.r21 - m.r12, root);
        o.quat_x = big;
        o.quat_y = scaled_ratio(m.r01 + m.r10, root);
        o.quat_z = scaled_ratio(m.r02 + m.r20, root);
      end
      rmq_pkg::AX_Y: begin
        o.quat_w = scaled_ratio(m.r02 - m.r20, root);
        o.quat_x = scaled_ratio(m.r01 + m.r10, root);
        o.quat_y = big;
        o.quat_z = scaled_ratio(m.r12 + m.r21, root);
      end
      default: begin
        o.quat_w = scaled_ratio(m.r10 - m.r01, root);
        o.quat_x = scaled_ratio(m.r02 + m.r20, root);
        o.quat_y = scaled_ratio(m.r12 + m.r21, root);
        o.quat_z = big;
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = quat_queue.size();

  always @(posedge clk) begin
    rmq_pkg::out_t want;
    if (rst_n && start && !busy) quat_queue = {quat_queue, quat_from_matrix(in_data)};
    if (rst_n && out_valid) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = quat_queue.pop_front();
        if (out_data.quat_w !== want.quat_w)
          report_mismatch("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.quat_x !== want.quat_x)
          report_mismatch("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y)
          report_mismatch("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z)
          report_mismatch("quat_z", out_data.quat_z, want.quat_z);
        if (out_data.bad_input !== want.bad_input)
          report_mismatch("bad_input", out_data.bad_input, want.bad_input);
      end
    end
  end
endmodule

### bench/tb.sv
// Testbench top: drives matrices into the converter and gives the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int LIMIT = 2000;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  rmq_pkg::in_t   in_data;
  logic           out_valid;
  rmq_pkg::out_t  out_data;
  int             errors;
  int             pending;
  int             quiet;
  int             idle_pct;

  rotation_matrix_to_quaternion i_dut (.*);
  rmq_tb_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'($urandom_range(0, 32768) - 16384);
      3: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rmq_pkg::in_t random_matrix();
    rmq_pkg::in_t m;
    m.r00 = pick_elem(); m.r01 = pick_elem(); m.r02 = pick_elem();
    m.r10 = pick_elem(); m.r11 = pick_elem(); m.r12 = pick_elem();
    m.r20 = pick_elem(); m.r21 = pick_elem(); m.r22 = pick_elem();
    return m;
  endfunction

  function automatic rmq_pkg::in_t near_rotation();
    rmq_pkg::in_t m;
    int a;
    int b;
    m = '0;
    a = $urandom_range(0, 32768) - 16384;
    b = $urandom_range(0, 1) ? 16384 : -16384;
    case ($urandom_range(0, 3))
      0: begin
        m.r00 = 16'(b); m.r11 = 16'(a); m.r22 = 16'(a); m.r12 = 16'(a); m.r21 = 16'(-a);
      end
      1: begin
        m.r11 = 16'(b); m.r00 = 16'(-a); m.r22 = 16'(a); m.r02 = 16'(a); m.r20 = 16'(a);
      end
      2: begin
        m.r22 = 16'(b); m.r00 = 16'(a); m.r11 = 16'(-a); m.r01 = 16'(a); m.r10 = 16'(-a);
      end
      default: begin m.r00 = 16'(b); m.r11 = 16'(-b); m.r22 = 16'(-b); end
    endcase
    m.r01 = m.r01 + 16'($urandom_range(0, 64) - 32);
    m.r22 = m.r22 + 16'($urandom_range(0, 64) - 32);
    return m;
  endfunction

  task automatic send_matrix(input rmq_pkg::in_t m);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rmq_pkg::in_t m;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    quiet = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    m = '0; m.r00 = 16384; m.r11 = 16384; m.r22 = 16384; send_matrix(m);
    m = '0; m.r00 = 16384; m.r11 = -16384; m.r22 = -16384; send_matrix(m);
    m = '0; m.r00 = -16384; m.r11 = 16384; m.r22 = -16384; send_matrix(m);
    m = '0; m.r00 = -16384; m.r11 = -16384; m.r22 = 16384; send_matrix(m);
    m = '0; send_matrix(m);
    m = '0; m.r00 = -16384; m.r11 = -16384; m.r22 = -16384; send_matrix(m);
    m = '0; m.r00 = 5000; m.r11 = 5000; m.r22 = -10000; send_matrix(m);
    m = '0; m.r00 = -16384; m.r11 = -16384; m.r22 = -16384;
    m.r01 = 32767; m.r10 = 32767; send_matrix(m);
    m = '0; m.r00 = 32767; m.r11 = -32768; m.r22 = -32768; send_matrix(m);
    m = {9{16'sh7fff}}; send_matrix(m);
    m = {9{16'sh8000}}; send_matrix(m);
    m = '0; m.r00 = 1; m.r11 = -32768; m.r22 = -32768;
    m.r21 = 32767; m.r12 = -32768; send_matrix(m);
    m = '0; m.r00 = -8000; m.r11 = -8000; m.r22 = -8000;
    m.r02 = 32767; m.r20 = 32767; send_matrix(m);
    m = {16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
         16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};
    send_matrix(m);
    m = ~m; send_matrix(m);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: idle_pct = 59;
        3: idle_pct = 12;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < 260; k++) begin
        if ($urandom_range(0, 2) == 0) send_matrix(random_matrix());
        else send_matrix(near_rotation());
      end
      if (ph == 2) drain();
    end

    drain();
    repeat (rmq_pkg::TOT_LAT + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### files.f
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion.sv
sv/rmq_checker.sv
bench/rmq_checker.sv
bench/tb.sv
